@@ sv/pcpc_pkg.sv @@
// shared types, constants and helpers of the pixel color classifier
package pcpc_pkg;

    localparam int CHAN_W      = 8;
    localparam int WEIGHT_W    = 7;
    localparam int REG_W       = 3 * WEIGHT_W;
    localparam int CFG_INDEX_W = 4;
    localparam int REG_COUNT   = 8;
    localparam int IDX_W       = 3;
    localparam int CLASS_W     = 4;
    localparam int PROD_W      = CHAN_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int SCORE_W     = 15;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 7'd100;
    localparam logic [SCORE_W-1:0]  SCORE_CLAMP = 15'd25500;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [SCORE_W-1:0] best_score;
        logic [IDX_W-1:0]   best_idx;
    } stage_t;

    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
        return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
    endfunction

endpackage

@@ sv/pcpc_cell.sv @@
// one neuron cell: holds its weights, scores the passing pixel, keeps the running best
module pcpc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              wr_en,
    input  logic [pcpc_pkg::REG_W-1:0]        wr_data,
    input  logic                              up_valid,
    input  pcpc_pkg::stage_t                  up,
    output logic                              dn_valid,
    output pcpc_pkg::stage_t                  dn
);

    logic [pcpc_pkg::REG_W-1:0]    weights_reg;
    logic [pcpc_pkg::WEIGHT_W-1:0] w_red;
    logic [pcpc_pkg::WEIGHT_W-1:0] w_green;
    logic [pcpc_pkg::WEIGHT_W-1:0] w_blue;
    logic [pcpc_pkg::PROD_W-1:0]   p_red;
    logic [pcpc_pkg::PROD_W-1:0]   p_green;
    logic [pcpc_pkg::PROD_W-1:0]   p_blue;
    logic [pcpc_pkg::SUM_W-1:0]    sum;
    logic [pcpc_pkg::SCORE_W-1:0]  score;
    logic                          valid_reg;
    pcpc_pkg::stage_t              stage_reg;
    pcpc_pkg::stage_t              stage_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= '0;
        end
        else if (wr_en)
        begin
            weights_reg <= wr_data;
        end
    end

    assign w_red   = pcpc_pkg::sat_weight(weights_reg[pcpc_pkg::WEIGHT_W-1:0]);
    assign w_green = pcpc_pkg::sat_weight(weights_reg[2*pcpc_pkg::WEIGHT_W-1:pcpc_pkg::WEIGHT_W]);
    assign w_blue  = pcpc_pkg::sat_weight(weights_reg[3*pcpc_pkg::WEIGHT_W-1:2*pcpc_pkg::WEIGHT_W]);

    assign p_red   = pcpc_pkg::PROD_W'(up.red)   * pcpc_pkg::PROD_W'(w_red);
    assign p_green = pcpc_pkg::PROD_W'(up.green) * pcpc_pkg::PROD_W'(w_green);
    assign p_blue  = pcpc_pkg::PROD_W'(up.blue)  * pcpc_pkg::PROD_W'(w_blue);

    assign sum = pcpc_pkg::SUM_W'(p_red) + pcpc_pkg::SUM_W'(p_green)
               + pcpc_pkg::SUM_W'(p_blue);

    assign score = (sum > pcpc_pkg::SUM_W'(pcpc_pkg::SCORE_CLAMP))
                 ? pcpc_pkg::SCORE_CLAMP : sum[pcpc_pkg::SCORE_W-1:0];

    // strict compare so the lower index keeps a tie
    always_comb
    begin
        stage_next = up;
        if (score > up.best_score)
        begin
            stage_next.best_score = score;
            stage_next.best_idx   = pcpc_pkg::IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = stage_reg;

endmodule

@@ sv/pixel_color_perceptron_classifier_core.sv @@
// top level of the pixel color classifier: input skid stage and a chain of neuron cells
//
//  channel   direction  handshake                    payload
//  pixel     in         pixel_valid / pixel_stall    red, green, blue
//  class     out        class_valid / class_stall    color_class
//  cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// one pixel per clock while class is not stalled; each neuron cell registers the pixel in turn,
// and the last cell's register is the output register
// reset clears all weights, so every pixel classifies as 1 until weights are written
// a stall on class freezes the chain; the pixel taken in that cycle waits in the skid
// register and pixel_stall rises on the following cycle until the chain moves again
module pixel_color_perceptron_classifier_core #(
    parameter int NEURON_COUNT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [pcpc_pkg::CHAN_W-1:0]         red,
    input  logic [pcpc_pkg::CHAN_W-1:0]         green,
    input  logic [pcpc_pkg::CHAN_W-1:0]         blue,
    output logic                                class_valid,
    input  logic                                class_stall,
    output logic [pcpc_pkg::CLASS_W-1:0]        color_class,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcpc_pkg::REG_W-1:0]          cfg_data
);

    logic             en;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    pcpc_pkg::stage_t skid_reg;
    pcpc_pkg::stage_t pix_item;
    logic             link_valid [NEURON_COUNT+1];
    pcpc_pkg::stage_t link       [NEURON_COUNT+1];

    assign en          = !(class_valid && class_stall);
    assign pixel_stall = skid_valid_reg;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        pix_item            = '0;
        pix_item.red        = red;
        pix_item.green      = green;
        pix_item.blue       = blue;
    end

    always_comb
    begin
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else
        begin
            skid_valid_next = skid_valid_reg || pixel_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && !skid_valid_reg)
        begin
            skid_reg <= pix_item;
        end
    end

    assign link_valid[0] = skid_valid_reg || pixel_valid;
    assign link[0]       = skid_valid_reg ? skid_reg : pix_item;

    for (genvar n = 0; n < NEURON_COUNT; n++)
    begin : g_cell
        pcpc_cell #(
            .CELL_IDX (n)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .wr_en    (cfg_valid && (cfg_index == pcpc_pkg::CFG_INDEX_W'(n))),
            .wr_data  (cfg_data),
            .up_valid (link_valid[n]),
            .up       (link[n]),
            .dn_valid (link_valid[n+1]),
            .dn       (link[n+1])
        );
    end

    assign class_valid = link_valid[NEURON_COUNT];
    assign color_class = pcpc_pkg::CLASS_W'(link[NEURON_COUNT].best_idx)
                       + pcpc_pkg::CLASS_W'(1);

endmodule

@@ sv/pcpc_checker.sv @@
// port-level checks of the pixel color classifier, bound to the top level
module pcpc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              pixel_valid,
    input logic                              pixel_stall,
    input logic                              class_valid,
    input logic                              class_stall,
    input logic [pcpc_pkg::CLASS_W-1:0]      color_class,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        class_valid && class_stall |=> class_valid && $stable(color_class))
        else $error("class item changed while stalled");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        class_valid |-> (color_class != 4'd0) && (color_class <= 4'd8))
        else $error("color_class out of range");

    // pixel side backs up only after the result side held a stalled item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_stall) |-> $past(class_valid && class_stall && pixel_valid))
        else $error("pixel_stall rose without a stalled result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write refused");

endmodule

bind pixel_color_perceptron_classifier_core pcpc_checker u_pcpc_checker (.*);
